@@ hdl/mtq_pkg.sv @@
// Shared types, widths and helpers for the matrix to quaternion pipeline.
package mtq_pkg;

    localparam int ELEM_W     = 16;
    localparam int CORNER_W   = 15;
    localparam int Q_W        = 16;
    localparam int D_W        = 17;
    localparam int SQ_N_W     = 29;
    localparam int SQ_W       = 30;
    localparam int SQRT_STEPS = 15;
    localparam int SQRT_LAT   = SQRT_STEPS + 1;
    localparam int ROOT_W     = 15;
    localparam int DIV_W      = 32;
    localparam int QUO_W      = 17;
    localparam int DIV_STEPS  = QUO_W;
    localparam int LANES      = 4;
    localparam int PIPE_LAT   = 1 + SQRT_LAT + 1 + DIV_STEPS + 1 + DIV_STEPS + 1;

    localparam logic [CORNER_W-1:0] CORNER_ONE = CORNER_W'(16384);
    localparam logic [Q_W-1:0]      Q_ONE      = Q_W'(16384);
    localparam logic [Q_W-1:0]      Q_POS_MAX  = Q_W'(32767);
    localparam logic [Q_W-1:0]      Q_NEG_MAX  = Q_W'(32768);

    // lane order x, y, z, w
    typedef enum logic [1:0] {SEL_X, SEL_Y, SEL_Z, SEL_W} sel_t;

    typedef struct packed {
        logic [LANES-1:0][D_W-1:0] d;
        sel_t                      sel;
        logic                      cone;
        logic                      bad;
    } front_t;

    typedef struct packed {
        logic [LANES-1:0]  neg;
        logic [LANES-1:0]  huge;
        sel_t              sel;
        logic              cone;
        logic              bad;
        logic [ROOT_W-1:0] qd;
        logic [ROOT_W-1:0] root;
    } mid_t;

    typedef struct packed {
        logic [LANES-1:0][QUO_W-1:0] mag;
        logic [LANES-1:0]            neg;
        logic [LANES-1:0]            huge_q;
        logic [LANES-1:0]            huge_c;
        logic                        cone;
        logic                        bad;
    } back_t;

    // sign-magnitude to saturated two's complement
    function automatic logic [Q_W-1:0] sat_q(input logic [QUO_W-1:0] mag,
                                             input logic neg, input logic huge);
        logic [QUO_W-1:0] neg_mag;
        logic [Q_W-1:0]   res;
        neg_mag = QUO_W'(0) - mag;
        if (!neg)
            res = (huge || mag > QUO_W'(Q_POS_MAX)) ? Q_POS_MAX : mag[Q_W-1:0];
        else
            res = (huge || mag > QUO_W'(Q_NEG_MAX)) ? Q_NEG_MAX : neg_mag[Q_W-1:0];
        return res;
    endfunction

endpackage

@@ hdl/mtq_front.sv @@
// Input stage: trace, branch choice, root argument and off-diagonal terms.
module mtq_front import mtq_pkg::*;
(
    input  logic                       clk,
    input  logic signed [ELEM_W-1:0]   elem_00,
    input  logic signed [ELEM_W-1:0]   elem_01,
    input  logic signed [ELEM_W-1:0]   elem_02,
    input  logic signed [ELEM_W-1:0]   elem_10,
    input  logic signed [ELEM_W-1:0]   elem_11,
    input  logic signed [ELEM_W-1:0]   elem_12,
    input  logic signed [ELEM_W-1:0]   elem_20,
    input  logic signed [ELEM_W-1:0]   elem_21,
    input  logic signed [ELEM_W-1:0]   elem_22,
    input  logic        [CORNER_W-1:0] corner_33,
    output front_t                     front,
    output logic        [SQ_N_W-1:0]   n_a,
    output logic        [SQ_N_W-1:0]   n_c
);

    front_t              front_reg, front_next;
    logic [SQ_N_W-1:0]   n_a_reg, n_a_next;
    logic [SQ_N_W-1:0]   n_c_reg;
    logic signed [17:0]  tr;
    logic signed [18:0]  cext;
    logic signed [18:0]  a;
    logic signed [D_W-1:0] dif_a, dif_b, dif_c, s01, s02, s12;
    logic                i1, i2;
    logic signed [ELEM_W-1:0] dmax;

    always_comb
    begin
        tr    = 18'(elem_00) + 18'(elem_11) + 18'(elem_22);
        cext  = 19'(corner_33);
        dif_a = D_W'(elem_12) - D_W'(elem_21);
        dif_b = D_W'(elem_20) - D_W'(elem_02);
        dif_c = D_W'(elem_01) - D_W'(elem_10);
        s01   = D_W'(elem_01) + D_W'(elem_10);
        s02   = D_W'(elem_02) + D_W'(elem_20);
        s12   = D_W'(elem_12) + D_W'(elem_21);
        i1    = elem_11 > elem_00;
        dmax  = i1 ? elem_11 : elem_00;
        i2    = elem_22 > dmax;
        front_next   = '0;
        front_next.d = '0;
        priority if (tr > 18'sd0)
        begin
            front_next.sel  = SEL_W;
            a               = 19'(tr) + cext;
            front_next.d[0] = dif_a;
            front_next.d[1] = dif_b;
            front_next.d[2] = dif_c;
        end
        else if (i2)
        begin
            front_next.sel  = SEL_Z;
            a               = 19'(elem_22) - 19'(elem_00) - 19'(elem_11) + cext;
            front_next.d[3] = dif_c;
            front_next.d[0] = s02;
            front_next.d[1] = s12;
        end
        else if (i1)
        begin
            front_next.sel  = SEL_Y;
            a               = 19'(elem_11) - 19'(elem_22) - 19'(elem_00) + cext;
            front_next.d[3] = dif_b;
            front_next.d[2] = s12;
            front_next.d[0] = s01;
        end
        else
        begin
            front_next.sel  = SEL_X;
            a               = 19'(elem_00) - 19'(elem_11) - 19'(elem_22) + cext;
            front_next.d[3] = dif_a;
            front_next.d[1] = s01;
            front_next.d[2] = s02;
        end
        front_next.cone = (corner_33 == CORNER_ONE);
        // bad root argument, or a zero corner that would need its own root
        front_next.bad  = a[18] || (a == 19'sd0) || (corner_33 == '0);
        n_a_next = (a[18] || a == 19'sd0) ? '0 : {a[16:0], 12'b0};
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        n_a_reg   <= n_a_next;
        n_c_reg   <= {corner_33, 14'b0};
    end

    assign front = front_reg;
    assign n_a   = n_a_reg;
    assign n_c   = n_c_reg;

endmodule

@@ hdl/mtq_sqrt.sv @@
// Pipelined square root, one result bit per stage, rounded to nearest.
module mtq_sqrt import mtq_pkg::*;
(
    input  logic              clk,
    input  logic [SQ_N_W-1:0] n,
    output logic [ROOT_W-1:0] root
);

    logic [SQ_W-1:0]   x_reg  [SQRT_STEPS];
    logic [SQ_W-1:0]   r_reg  [SQRT_STEPS];
    logic [SQ_W-1:0]   x_next [SQRT_STEPS];
    logic [SQ_W-1:0]   r_next [SQRT_STEPS];
    logic [ROOT_W-1:0] root_reg, root_next;

    always_comb
    begin
        logic [SQ_W-1:0] xi, ri, bitv, trial;
        for (int s = 0; s < SQRT_STEPS; s++)
        begin
            if (s == 0)
            begin
                xi = SQ_W'(n);
                ri = '0;
            end
            else
            begin
                xi = x_reg[s-1];
                ri = r_reg[s-1];
            end
            bitv  = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - s));
            trial = ri + bitv;
            if (xi >= trial)
            begin
                x_next[s] = xi - trial;
                r_next[s] = (ri >> 1) + bitv;
            end
            else
            begin
                x_next[s] = xi;
                r_next[s] = ri >> 1;
            end
        end
        // remainder above root means round up
        root_next = ROOT_W'(r_reg[SQRT_STEPS-1]
                    + SQ_W'(x_reg[SQRT_STEPS-1] > r_reg[SQRT_STEPS-1]));
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < SQRT_STEPS; s++)
        begin
            x_reg[s] <= x_next[s];
            r_reg[s] <= r_next[s];
        end
        root_reg <= root_next;
    end

    assign root = root_reg;

endmodule

@@ hdl/mtq_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module mtq_div import mtq_pkg::*;
(
    input  logic              clk,
    input  logic [DIV_W-1:0]  num,
    input  logic [ROOT_W-1:0] den,
    output logic [QUO_W-1:0]  quo
);

    logic [DIV_W-1:0]  rem_reg  [DIV_STEPS];
    logic [DIV_W-1:0]  rem_next [DIV_STEPS];
    logic [ROOT_W-1:0] den_reg  [DIV_STEPS];
    logic [ROOT_W-1:0] den_next [DIV_STEPS];
    logic [QUO_W-1:0]  quo_reg  [DIV_STEPS];
    logic [QUO_W-1:0]  quo_next [DIV_STEPS];

    always_comb
    begin
        logic [DIV_W-1:0]  ri, trial;
        logic [ROOT_W-1:0] di;
        logic [QUO_W-1:0]  qi;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            if (s == 0)
            begin
                ri = num;
                di = den;
                qi = '0;
            end
            else
            begin
                ri = rem_reg[s-1];
                di = den_reg[s-1];
                qi = quo_reg[s-1];
            end
            trial       = DIV_W'(di) << (DIV_STEPS - 1 - s);
            den_next[s] = di;
            if (ri >= trial)
            begin
                rem_next[s] = ri - trial;
                quo_next[s] = {qi[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = ri;
                quo_next[s] = {qi[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            rem_reg[s] <= rem_next[s];
            den_reg[s] <= den_next[s];
            quo_reg[s] <= quo_next[s];
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];

endmodule

@@ hdl/matrix_to_quaternion.sv @@
// Rotation matrix to quaternion converter: top level and pipeline control.
// Fully pipelined: a new word is taken every cycle (busy stays low) and its
// quaternion appears on the result ports, marked by done for one cycle,
// after the input register, a 16-stage square root, a register, two
// 17-stage dividers in series (off-diagonal terms over the dominant
// component, then scaling by the corner root) with a register between
// them, and the output register. The receiver cannot stall the block; results are
// shown once and must be taken when done is high.
module matrix_to_quaternion import mtq_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [ELEM_W-1:0]   elem_00,
    input  logic signed [ELEM_W-1:0]   elem_01,
    input  logic signed [ELEM_W-1:0]   elem_02,
    input  logic signed [ELEM_W-1:0]   elem_10,
    input  logic signed [ELEM_W-1:0]   elem_11,
    input  logic signed [ELEM_W-1:0]   elem_12,
    input  logic signed [ELEM_W-1:0]   elem_20,
    input  logic signed [ELEM_W-1:0]   elem_21,
    input  logic signed [ELEM_W-1:0]   elem_22,
    input  logic        [CORNER_W-1:0] corner_33,
    output logic                       done,
    output logic signed [Q_W-1:0]      quat_x,
    output logic signed [Q_W-1:0]      quat_y,
    output logic signed [Q_W-1:0]      quat_z,
    output logic signed [Q_W-1:0]      quat_w,
    output logic                       degenerate
);

    logic [PIPE_LAT-1:0] valid_reg;
    front_t              front;
    logic [SQ_N_W-1:0]   n_a, n_c;
    logic [ROOT_W-1:0]   qd, root;

    front_t              sb1_reg [SQRT_LAT];
    mid_t                mid_reg, mid_next;
    mid_t                sb2_reg [DIV_STEPS];
    logic [DIV_W-1:0]    num1_reg [LANES];
    logic [DIV_W-1:0]    num1_next [LANES];
    logic [QUO_W-1:0]    quo1 [LANES];
    back_t               back_reg, back_next;
    back_t               sb3_reg [DIV_STEPS];
    logic [DIV_W-1:0]    num2_reg [LANES];
    logic [DIV_W-1:0]    num2_next [LANES];
    logic [ROOT_W-1:0]   root2_reg;
    logic [QUO_W-1:0]    quo2 [LANES];
    logic [LANES-1:0][Q_W-1:0] q_reg, q_next;
    logic                bad_reg;

    assign busy = 1'b0;

    mtq_front u_front (
        .clk       (clk),
        .elem_00   (elem_00),
        .elem_01   (elem_01),
        .elem_02   (elem_02),
        .elem_10   (elem_10),
        .elem_11   (elem_11),
        .elem_12   (elem_12),
        .elem_20   (elem_20),
        .elem_21   (elem_21),
        .elem_22   (elem_22),
        .corner_33 (corner_33),
        .front     (front),
        .n_a       (n_a),
        .n_c       (n_c)
    );

    mtq_sqrt u_sqrt_a (.clk(clk), .n(n_a), .root(qd));
    mtq_sqrt u_sqrt_c (.clk(clk), .n(n_c), .root(root));

    // off-diagonal terms to sign-magnitude, scaled for the first divide
    always_comb
    begin
        front_t             f;
        logic signed [D_W-1:0] dv;
        logic [D_W-1:0]     mag;
        f = sb1_reg[SQRT_LAT-1];
        mid_next.sel  = f.sel;
        mid_next.cone = f.cone;
        mid_next.bad  = f.bad;
        mid_next.qd   = qd;
        mid_next.root = root;
        for (int n = 0; n < LANES; n++)
        begin
            dv  = $signed(f.d[n]);
            mid_next.neg[n]  = dv[D_W-1];
            mag = dv[D_W-1] ? D_W'(-dv) : D_W'(dv);
            // quotient would reach 2^17: result saturates regardless
            mid_next.huge[n] = {3'b0, mag} >= {qd, 5'b0};
            num1_next[n] = DIV_W'({mag, 12'b0}) + DIV_W'(qd >> 1);
        end
    end

    generate
        for (genvar n = 0; n < LANES; n++)
        begin : g_div1
            mtq_div u_div (.clk(clk), .num(num1_reg[n]), .den(mid_reg.qd), .quo(quo1[n]));
        end
    endgenerate

    // dominant lane takes the root; all lanes set up for the corner divide
    always_comb
    begin
        mid_t             m;
        logic [QUO_W-1:0] mag;
        m = sb2_reg[DIV_STEPS-1];
        back_next.cone = m.cone;
        back_next.bad  = m.bad;
        for (int n = 0; n < LANES; n++)
        begin
            if (m.sel == sel_t'(2'(n)))
            begin
                mag = QUO_W'(m.qd);
                back_next.neg[n]    = 1'b0;
                back_next.huge_q[n] = 1'b0;
            end
            else
            begin
                mag = quo1[n];
                back_next.neg[n]    = m.neg[n];
                back_next.huge_q[n] = m.huge[n];
            end
            back_next.mag[n]    = mag;
            back_next.huge_c[n] = {2'b0, mag} >= {2'b0, m.root, 2'b0};
            num2_next[n] = DIV_W'({mag, 14'b0}) + DIV_W'(m.root >> 1);
        end
    end

    generate
        for (genvar n = 0; n < LANES; n++)
        begin : g_div2
            mtq_div u_div (.clk(clk), .num(num2_reg[n]), .den(root2_reg), .quo(quo2[n]));
        end
    endgenerate

    always_comb
    begin
        back_t            b;
        logic [QUO_W-1:0] mag;
        logic             huge;
        b = sb3_reg[DIV_STEPS-1];
        for (int n = 0; n < LANES; n++)
        begin
            if (b.cone)
            begin
                mag  = b.mag[n];
                huge = b.huge_q[n];
            end
            else
            begin
                mag  = quo2[n];
                huge = b.huge_q[n] || b.huge_c[n];
            end
            q_next[n] = b.bad ? ((n == LANES - 1) ? Q_ONE : '0)
                              : sat_q(mag, b.neg[n], huge);
        end
    end

    always_ff @(posedge clk)
    begin
        sb1_reg[0] <= front;
        for (int s = 1; s < SQRT_LAT; s++)
            sb1_reg[s] <= sb1_reg[s-1];
        mid_reg <= mid_next;
        for (int n = 0; n < LANES; n++)
        begin
            num1_reg[n] <= num1_next[n];
            num2_reg[n] <= num2_next[n];
        end
        sb2_reg[0] <= mid_reg;
        for (int s = 1; s < DIV_STEPS; s++)
            sb2_reg[s] <= sb2_reg[s-1];
        back_reg  <= back_next;
        root2_reg <= sb2_reg[DIV_STEPS-1].root;
        sb3_reg[0] <= back_reg;
        for (int s = 1; s < DIV_STEPS; s++)
            sb3_reg[s] <= sb3_reg[s-1];
        q_reg   <= q_next;
        bad_reg <= sb3_reg[DIV_STEPS-1].bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[PIPE_LAT-2:0], start & ~busy};
    end

    assign done       = valid_reg[PIPE_LAT-1];
    assign quat_x     = q_reg[0];
    assign quat_y     = q_reg[1];
    assign quat_z     = q_reg[2];
    assign quat_w     = q_reg[3];
    assign degenerate = bad_reg;

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##PIPE_LAT done)
        else $error("accepted word did not complete after pipeline latency");

    a_identity: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (quat_x == '0 && quat_y == '0 && quat_z == '0
                                  && quat_w == Q_ONE))
        else $error("degenerate result is not the identity");

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(start) |-> !busy)
        else $error("block refused a word");
`endif

endmodule

@@ verif/matrix_to_quaternion_tb.sv @@
// Self-checking testbench for the matrix to quaternion converter.
module matrix_to_quaternion_tb;
    import mtq_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [ELEM_W-1:0] elem_00, elem_01, elem_02, elem_10, elem_11;
    logic signed [ELEM_W-1:0] elem_12, elem_20, elem_21, elem_22;
    logic [CORNER_W-1:0] corner_33;
    logic done;
    logic signed [Q_W-1:0] quat_x, quat_y, quat_z, quat_w;
    logic degenerate;

    typedef struct packed {
        logic signed [Q_W-1:0] x;
        logic signed [Q_W-1:0] y;
        logic signed [Q_W-1:0] z;
        logic signed [Q_W-1:0] w;
        logic                  bad;
    } quat_t;

    quat_t quat_q[$];
    int    mismatches;
    int    burst_left;

    matrix_to_quaternion dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .elem_00(elem_00), .elem_01(elem_01), .elem_02(elem_02),
        .elem_10(elem_10), .elem_11(elem_11), .elem_12(elem_12),
        .elem_20(elem_20), .elem_21(elem_21), .elem_22(elem_22),
        .corner_33(corner_33), .done(done),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
        .degenerate(degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("matrix_to_quaternion regression: fail");
        $finish;
    end

    function automatic longint isqrt_near(input longint n);
        longint r;
        longint b;
        longint x;
        r = 0;
        x = n;
        b = 64'sd1 <<< 62;
        while (b > n) b = b >>> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        if (x > r) r = r + 1;
        return r;
    endfunction

    function automatic longint div_near(input longint num, input longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic logic signed [Q_W-1:0] clamp_q(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[Q_W-1:0];
    endfunction

    // Shepperd conversion in wide integers; m is row-major, c the corner
    function automatic quat_t convert_matrix(input longint m[9], input longint c);
        longint q[4];
        longint a, qd, tr, root;
        int     i, j, k, n;
        logic   bad;
        quat_t  res;
        bad = 1'b0;
        tr = m[0] + m[4] + m[8];
        if (tr > 0)
        begin
            a = tr + c;
            bad = (a <= 0);
            qd = bad ? 1 : isqrt_near(a * 4096);
            q[3] = qd;
            q[0] = div_near((m[5] - m[7]) * 4096, qd);
            q[1] = div_near((m[6] - m[2]) * 4096, qd);
            q[2] = div_near((m[1] - m[3]) * 4096, qd);
        end
        else
        begin
            i = 0;
            if (m[4] > m[0]) i = 1;
            if (m[8] > m[i*4]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            a = m[i*4] - (m[j*4] + m[k*4]) + c;
            bad = (a <= 0);
            qd = bad ? 1 : isqrt_near(a * 4096);
            q[i] = qd;
            q[3] = div_near((m[j*3+k] - m[k*3+j]) * 4096, qd);
            q[j] = div_near((m[i*3+j] + m[j*3+i]) * 4096, qd);
            q[k] = div_near((m[i*3+k] + m[k*3+i]) * 4096, qd);
        end
        if (!bad && c != 16384)
        begin
            if (c <= 0)
                bad = 1'b1;
            else
            begin
                root = isqrt_near(c * 16384);
                for (n = 0; n < 4; n++)
                    q[n] = div_near(q[n] * 16384, root);
            end
        end
        if (bad)
        begin
            q[0] = 0; q[1] = 0; q[2] = 0; q[3] = 16384;
        end
        res.x = clamp_q(q[0]);
        res.y = clamp_q(q[1]);
        res.z = clamp_q(q[2]);
        res.w = clamp_q(q[3]);
        res.bad = bad;
        return res;
    endfunction

    // sends one word, with bursty gaps; start stays high inside a burst
    task automatic send_matrix(input logic signed [15:0] e[9], input logic [14:0] c);
        longint m[9];
        int     gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        elem_00 <= e[0]; elem_01 <= e[1]; elem_02 <= e[2];
        elem_10 <= e[3]; elem_11 <= e[4]; elem_12 <= e[5];
        elem_20 <= e[6]; elem_21 <= e[7]; elem_22 <= e[8];
        corner_33 <= c;
        @(posedge clk);
        while (busy) @(posedge clk);
        for (int n = 0; n < 9; n++) m[n] = e[n];
        quat_q.push_back(convert_matrix(m, c));
    endtask

    // checks each result as it is shown
    always @(posedge clk)
    begin
        quat_t got, want;
        if (rst_n && done)
        begin
            got = '{quat_x, quat_y, quat_z, quat_w, degenerate};
            if (quat_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end
            else
            begin
                want = quat_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d %0d %0b got %0d %0d %0d %0d %0b",
                            want.x, want.y, want.z, want.w, want.bad,
                            got.x, got.y, got.z, got.w, got.bad);
                end
            end
        end
    end

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
        endcase
    endfunction

    function automatic logic [14:0] rand_corner();
        case ($urandom_range(0, 5))
            0: return 15'd16384;
            1: return 15'($urandom);
            2: return 15'($urandom_range(0, 3));
            default: return 15'($urandom_range(8192, 24576));
        endcase
    endfunction

    task automatic test_directed();
        logic signed [15:0] e[9];
        // identity, unit corner
        e = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
        send_matrix(e, 15'd16384);
        // 180 degree turns pick each dominant axis
        e = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
        send_matrix(e, 15'd16384);
        e = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};
        send_matrix(e, 15'd16384);
        e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
        send_matrix(e, 15'd16384);
        // zero corner is degenerate; then a full-scale and a tiny corner
        e = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
        send_matrix(e, 15'd0);
        send_matrix(e, 15'h7fff);
        send_matrix(e, 15'd1);
        // all-zero matrix: trace zero, index 0 with ties
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_matrix(e, 15'd16384);
        send_matrix(e, 15'd0);
        // most negative diagonal; the root argument stays positive
        e = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};
        send_matrix(e, 15'd100);
        // equal diagonal ties with negative trace
        e = '{-100, 5, 7, 9, -100, 11, 13, 15, -100};
        send_matrix(e, 15'd16384);
        // saturation: huge off-diagonal differences, then extreme entries
        e = '{1, 32767, -32768, -32768, -1, 32767, 32767, -32768, 1};
        send_matrix(e, 15'd16384);
        e = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
        send_matrix(e, 15'h7fff);
        e = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
        send_matrix(e, 15'd16384);
        e = '{-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768, -32768};
        send_matrix(e, 15'd1);
        e = '{0, 16384, 0, -16384, 0, 0, 0, 0, 16384};
        send_matrix(e, 15'd8192);
    endtask

    task automatic test_random(input int count);
        logic signed [15:0] e[9];
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 9; i++) e[i] = rand_elem();
            send_matrix(e, rand_corner());
        end
    endtask

    initial
    begin
        int guard;
        rst_n = 1'b0;
        start = 1'b0;
        {elem_00, elem_01, elem_02, elem_10, elem_11} = '0;
        {elem_12, elem_20, elem_21, elem_22} = '0;
        corner_33 = '0;
        mismatches = 0;
        burst_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1500);
        start <= 1'b0;
        guard = 0;
        while (quat_q.size() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (PIPE_LAT + 10) @(posedge clk);
        if (mismatches == 0 && quat_q.size() == 0)
            $display("matrix_to_quaternion regression: pass");
        else
            $display("matrix_to_quaternion regression: fail");
        $finish;
    end
endmodule

@@ files.f @@
hdl/mtq_pkg.sv
hdl/mtq_front.sv
hdl/mtq_sqrt.sv
hdl/mtq_div.sv
hdl/matrix_to_quaternion.sv
verif/matrix_to_quaternion_tb.sv
